>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl, used by puf_seq
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is held
`define PUF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define PUF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/puf_pkg.sv
// shared types, constants and helpers of the parity union-find block
`default_nettype none
package puf_pkg;
  localparam int NUM_SETS   = 1024;
  localparam int SET_W      = 10;
  localparam int NODE_COUNT = 2 * NUM_SETS + 2;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int COST_W     = $clog2(NUM_SETS + 1);
  localparam int TOTAL_W    = 11;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [COST_W-1:0] cost_t;

  localparam node_t SENT_NODE = NODE_W'(2 * NUM_SETS);
  localparam node_t FORB_NODE = NODE_W'(2 * NUM_SETS + 1);
  localparam node_t LAST_NODE = NODE_W'(NODE_COUNT - 1);

  // one memory word per literal node
  typedef struct packed {
    node_t parent;
    cost_t cost;
    logic  forb;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // memory access request from the sequencer
  typedef struct packed {
    logic   rd_en;
    node_t  rd_addr;
    logic   wr_en;
    node_t  wr_addr;
    entry_t wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               infeasible;
  } result_t;

  // cheaper permitted side of a component
  function automatic cost_t cheaper(input cost_t ct, input logic ft,
                                    input cost_t cf, input logic ff);
    cost_t r;
    if (ft && !ff) r = cf;
    else if (ff && !ft) r = ct;
    else r = (ct < cf) ? ct : cf;
    return r;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/puf_in_if.sv
// request channel carrying one constraint
`default_nettype none
interface puf_in_if;
  import puf_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       member_count;
  logic [SET_W-1:0] set_a;
  logic [SET_W-1:0] set_b;
  logic             lamp_on;
  modport source (output valid, member_count, set_a, set_b, lamp_on, input ready);
  modport sink (input valid, member_count, set_a, set_b, lamp_on, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/puf_out_if.sv
// result channel carrying the running minimum cost
`default_nettype none
interface puf_out_if;
  import puf_pkg::*;
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total_cost;
  logic               infeasible;
  modport source (output valid, total_cost, infeasible, input ready);
  modport sink (input valid, total_cost, infeasible, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/parity_union_find_min_cost_top.sv
// Weighted parity union-find with running minimum cost, one result per request.
// A no-op request finishes straight from idle; otherwise 4 root finds over the single read
// port of the node memory, each with path compression; then DECIDE and, to merge, WTT-WAF.
// One request at a time; a new one is taken once the last result is in the output register.
// Reset: synchronous active-low rst_n, then a clearing pass over all 2050 words of the node
// memory during which no request is accepted.
`default_nettype none
module parity_union_find_min_cost_top
  import puf_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  puf_in_if.sink   in_ch,
  puf_out_if.source out_ch
);
  mem_req_t mem_req;
  entry_t   mem_rdata;
  logic     res_valid, res_take;
  result_t  res_data;
  logic     out_valid_r;
  result_t  out_data_r;
  logic [ENTRY_W-1:0] rdata_raw;

  puf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_count  (in_ch.member_count),
    .in_a      (in_ch.set_a),
    .in_b      (in_ch.set_b),
    .in_lamp   (in_ch.lamp_on),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_data  (res_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  puf_ram #(.DEPTH(NODE_COUNT), .WIDTH(ENTRY_W)) u_ram (
    .clk   (clk),
    .we    (mem_req.wr_en),
    .waddr (mem_req.wr_addr),
    .wdata (mem_req.wr_data),
    .re    (mem_req.rd_en),
    .raddr (mem_req.rd_addr),
    .rdata (rdata_raw)
  );

  assign mem_rdata = entry_t'(rdata_raw);

  // output register
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_data_r <= res_data;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.total_cost = out_data_r.total;
  assign out_ch.infeasible = out_data_r.infeasible;
endmodule
`default_nettype wire

>>> hw/rtl/puf_ram.sv
// generic one-write one-read synchronous ram, registered read data
`default_nettype none
module puf_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/puf_seq.sv
// sequencer: clearing pass, root finds with compression, merge and running total
`default_nettype none
`include "assert_macros.svh"
module puf_seq
  import puf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_count,
  input  wire logic [SET_W-1:0] in_a,
  input  wire logic [SET_W-1:0] in_b,
  input  wire logic             in_lamp,
  output logic                  res_valid,
  input  wire logic             res_take,
  output result_t               res_data,
  output mem_req_t              mem_req,
  input  wire entry_t           mem_rdata
);
  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_FDAT   = 9'b000000100,
    S_CDAT   = 9'b000001000,
    S_DECIDE = 9'b000010000,
    S_WTT    = 9'b000100000,
    S_WTF    = 9'b001000000,
    S_WAT    = 9'b010000000,
    S_WAF    = 9'b100000000
  } state_t;

  localparam logic [1:0] FIND_LAST = 2'd3;

  state_t             state_r, state_nxt;
  logic               finish_r, finish_nxt;
  node_t              clr_r, clr_nxt;
  node_t              cur_r, cur_nxt;
  logic [1:0]         k_r, k_nxt;
  node_t              root_r [4];
  cost_t              rcost_r [4];
  logic               rforb_r [4];
  logic               root_we;
  logic [SET_W-1:0]   a_r, b_r;
  logic               bsent_r, eq_r;
  logic               inf_r, inf_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [COST_W:0]    old_sum_r;
  cost_t              ntt_cost_r, ntf_cost_r;
  logic               ntt_forb_r, ntf_forb_r;
  logic               merge_we;
  node_t              tt_w, tf_w;
  cost_t              ctt_w, ctf_w;
  logic               ftt_w, ftf_w;
  logic               accept, op_ok, op_single;
  logic [COST_W+1:0]  total_wide;

  // start node of each of the four finds
  function automatic node_t start_node(input logic [1:0] k, input logic [SET_W-1:0] a,
                                       input logic [SET_W-1:0] b, input logic bsent);
    node_t n;
    unique case (k)
      2'd0: n = {1'b0, a, 1'b0};
      2'd1: n = {1'b0, a, 1'b1};
      2'd2: n = bsent ? SENT_NODE : {1'b0, b, 1'b0};
      default: n = bsent ? FORB_NODE : {1'b0, b, 1'b1};
    endcase
    return n;
  endfunction

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE) && !finish_r;
  assign op_single = (in_count == 2'd1) && ({1'b0, in_a} < (SET_W + 1)'(NUM_SETS));
  assign op_ok     = op_single || ((in_count == 2'd2)
                     && ({1'b0, in_a} < (SET_W + 1)'(NUM_SETS))
                     && ({1'b0, in_b} < (SET_W + 1)'(NUM_SETS)));

  // roots as seen from the a side
  assign tt_w  = eq_r ? root_r[2] : root_r[3];
  assign tf_w  = eq_r ? root_r[3] : root_r[2];
  assign ctt_w = eq_r ? rcost_r[2] : rcost_r[3];
  assign ctf_w = eq_r ? rcost_r[3] : rcost_r[2];
  assign ftt_w = eq_r ? rforb_r[2] : rforb_r[3];
  assign ftf_w = eq_r ? rforb_r[3] : rforb_r[2];

  assign total_wide = (COST_W + 2)'(total_r)
                    + (COST_W + 2)'(eq_r ? cheaper(ntt_cost_r, ntt_forb_r, ntf_cost_r, ntf_forb_r)
                                         : cheaper(ntf_cost_r, ntf_forb_r, ntt_cost_r, ntt_forb_r))
                    - (COST_W + 2)'(old_sum_r);

  // sequencer next state and memory requests
  always_comb begin
    state_nxt  = state_r;
    finish_nxt = finish_r;
    clr_nxt    = clr_r;
    cur_nxt    = cur_r;
    k_nxt      = k_r;
    inf_nxt    = inf_r;
    total_nxt  = total_r;
    root_we    = 1'b0;
    merge_we   = 1'b0;
    mem_req    = '0;
    if (finish_r && res_take) finish_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_req.wr_en          = 1'b1;
        mem_req.wr_addr        = clr_r;
        mem_req.wr_data.parent = clr_r;
        mem_req.wr_data.cost   = cost_t'(!clr_r[0] && clr_r < SENT_NODE);
        mem_req.wr_data.forb   = (clr_r == FORB_NODE);
        clr_nxt                = clr_r + 1'b1;
        if (clr_r == LAST_NODE) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (op_ok) begin
            cur_nxt         = {1'b0, in_a, 1'b0};
            k_nxt           = 2'd0;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = {1'b0, in_a, 1'b0};
            state_nxt       = S_FDAT;
          end else begin
            finish_nxt = 1'b1;
          end
        end
      end
      S_FDAT: begin
        mem_req.rd_en = 1'b1;
        if (mem_rdata.parent == cur_r) begin
          root_we         = 1'b1;
          cur_nxt         = start_node(k_r, a_r, b_r, bsent_r);
          mem_req.rd_addr = start_node(k_r, a_r, b_r, bsent_r);
          state_nxt       = S_CDAT;
        end else begin
          cur_nxt         = mem_rdata.parent;
          mem_req.rd_addr = mem_rdata.parent;
        end
      end
      S_CDAT: begin
        if (mem_rdata.parent == root_r[k_r]) begin
          if (k_r == FIND_LAST) begin
            state_nxt = S_DECIDE;
          end else begin
            k_nxt           = k_r + 1'b1;
            cur_nxt         = start_node(k_r + 1'b1, a_r, b_r, bsent_r);
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = start_node(k_r + 1'b1, a_r, b_r, bsent_r);
            state_nxt       = S_FDAT;
          end
        end else begin
          // point this node straight at its root
          mem_req.wr_en          = 1'b1;
          mem_req.wr_addr        = cur_r;
          mem_req.wr_data        = mem_rdata;
          mem_req.wr_data.parent = root_r[k_r];
          mem_req.rd_en          = 1'b1;
          mem_req.rd_addr        = mem_rdata.parent;
          cur_nxt                = mem_rdata.parent;
        end
      end
      S_DECIDE: begin
        if (root_r[0] == tt_w) begin
          finish_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else if (root_r[0] == tf_w) begin
          inf_nxt    = 1'b1;
          finish_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          merge_we  = 1'b1;
          state_nxt = S_WTT;
        end
      end
      S_WTT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = tt_w;
        mem_req.wr_data = '{parent: tt_w, cost: ntt_cost_r, forb: ntt_forb_r};
        state_nxt       = S_WTF;
      end
      S_WTF: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = tf_w;
        mem_req.wr_data = '{parent: tf_w, cost: ntf_cost_r, forb: ntf_forb_r};
        state_nxt       = S_WAT;
      end
      S_WAT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = root_r[0];
        mem_req.wr_data = '{parent: tt_w, cost: rcost_r[0], forb: rforb_r[0]};
        state_nxt       = S_WAF;
      end
      S_WAF: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = root_r[1];
        mem_req.wr_data = '{parent: tf_w, cost: rcost_r[1], forb: rforb_r[1]};
        total_nxt       = total_wide[TOTAL_W-1:0];
        finish_nxt      = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      finish_r <= 1'b0;
      clr_r    <= '0;
      inf_r    <= 1'b0;
      total_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      finish_r <= finish_nxt;
      clr_r    <= clr_nxt;
      inf_r    <= inf_nxt;
      total_r  <= total_nxt;
    end
  end

  // request and working registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    k_r   <= k_nxt;
    if (accept) begin
      a_r     <= in_a;
      b_r     <= in_b;
      bsent_r <= op_single;
      eq_r    <= op_single ? !in_lamp : in_lamp;
    end
    if (root_we) begin
      root_r[k_r]  <= cur_r;
      rcost_r[k_r] <= mem_rdata.cost;
      rforb_r[k_r] <= mem_rdata.forb;
    end
    if (merge_we) begin
      old_sum_r  <= (COST_W + 1)'(cheaper(rcost_r[0], rforb_r[0], rcost_r[1], rforb_r[1]))
                  + (COST_W + 1)'(cheaper(rcost_r[2], rforb_r[2], rcost_r[3], rforb_r[3]));
      ntt_cost_r <= ctt_w + rcost_r[0];
      ntt_forb_r <= ftt_w | rforb_r[0];
      ntf_cost_r <= ctf_w + rcost_r[1];
      ntf_forb_r <= ftf_w | rforb_r[1];
    end
  end

  assign res_valid           = finish_r;
  assign res_data.total      = total_r;
  assign res_data.infeasible = inf_r;

  `PUF_ASSERT(a_inf_sticky, clk, rst_n, inf_r |=> inf_r, "infeasible flag dropped")
  `PUF_ASSERT(a_merge_distinct, clk, rst_n, (state_r == S_WTF) |-> (tf_w != tt_w),
              "merge targets coincide")
  `PUF_ASSERT(a_total_bound, clk, rst_n, total_r <= TOTAL_W'(NUM_SETS),
              "running total above set count")
endmodule
`default_nettype wire

>>> test/tb_top.sv
// testbench for the parity union-find block: directed and random constraints vs a predictor
`default_nettype none

// expected results and the union-find predictor that produces them
class puf_scoreboard;
  localparam int NODES = puf_pkg::NODE_COUNT;
  int unsigned up_node [NODES];
  int unsigned side_sum [NODES];
  bit          side_forb [NODES];
  int unsigned total_acc;
  bit          infeas_acc;
  logic [puf_pkg::TOTAL_W-1:0] exp_total_q [$];
  bit                          exp_infeas_q [$];
  int errors;
  int results_seen;
  int infeas_seen;

  function new();
    for (int i = 0; i < NODES; i++) begin
      up_node[i] = i;
      side_sum[i] = (i % 2 == 0) ? 1 : 0;
      side_forb[i] = 0;
    end
    side_sum[2 * puf_pkg::NUM_SETS] = 0;
    side_sum[2 * puf_pkg::NUM_SETS + 1] = 0;
    side_forb[2 * puf_pkg::NUM_SETS + 1] = 1;
    total_acc = 0;
    infeas_acc = 0;
    errors = 0;
    results_seen = 0;
    infeas_seen = 0;
  endfunction

  // root lookup with path compression
  function int unsigned root_of(int unsigned x);
    int unsigned r;
    int unsigned nx;
    r = x;
    while (up_node[r] != r) r = up_node[r];
    while (up_node[x] != r) begin
      nx = up_node[x];
      up_node[x] = r;
      x = nx;
    end
    return r;
  endfunction

  function int unsigned min_side(int unsigned t, int unsigned f);
    if (side_forb[t] && !side_forb[f]) return side_sum[f];
    if (side_forb[f] && !side_forb[t]) return side_sum[t];
    return (side_sum[t] < side_sum[f]) ? side_sum[t] : side_sum[f];
  endfunction

  function void join_sets(int unsigned a, int unsigned b, bit same);
    int unsigned at, af, bt, bf, tt, tf, old_sum;
    at = root_of(2 * a);
    af = root_of(2 * a + 1);
    bt = root_of(2 * b);
    bf = root_of(2 * b + 1);
    tt = same ? bt : bf;
    tf = same ? bf : bt;
    if (at == tt) return;
    if (at == tf) begin
      infeas_acc = 1;
      return;
    end
    old_sum = min_side(at, af) + min_side(bt, bf);
    side_sum[tt] += side_sum[at];
    side_forb[tt] |= side_forb[at];
    side_sum[tf] += side_sum[af];
    side_forb[tf] |= side_forb[af];
    up_node[at] = tt;
    up_node[af] = tf;
    total_acc = total_acc + min_side(bt, bf) - old_sum;
  endfunction

  // note an accepted constraint request
  function void note_request(logic [1:0] cnt, int unsigned a, int unsigned b, bit lamp);
    if (cnt == 2'd1 && a < puf_pkg::NUM_SETS)
      join_sets(a, puf_pkg::NUM_SETS, lamp == 1'b0);
    else if (cnt == 2'd2 && a < puf_pkg::NUM_SETS && b < puf_pkg::NUM_SETS)
      join_sets(a, b, lamp == 1'b1);
    exp_total_q.insert(exp_total_q.size(), total_acc[puf_pkg::TOTAL_W-1:0]);
    exp_infeas_q.insert(exp_infeas_q.size(), infeas_acc);
  endfunction

  // compare one result against the oldest expectation
  function void check_result(logic [puf_pkg::TOTAL_W-1:0] tot, logic inf);
    logic [puf_pkg::TOTAL_W-1:0] et;
    bit ei;
    results_seen++;
    if (inf === 1'b1) infeas_seen++;
    if (exp_total_q.size() == 0) begin
      $display("%0t: unexpected result total=%0d infeasible=%0b", $time, tot, inf);
      errors++;
      return;
    end
    et = exp_total_q.pop_front();
    ei = exp_infeas_q.pop_front();
    if (tot !== et) begin
      $display("%0t: total_cost mismatch expected=%0d actual=%0d", $time, et, tot);
      errors++;
    end
    if (inf !== ei) begin
      $display("%0t: infeasible mismatch expected=%0b actual=%0b", $time, ei, inf);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import puf_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic clk;
  logic rst_n;
  puf_in_if  in_ch ();
  puf_out_if out_ch ();

  puf_scoreboard sb;
  int idle_cycles;
  bit timed_out;
  bit rand_stall;
  int out_hold;

  parity_union_find_min_cost_top u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one request, then wait for the handshake; valid stays up for a following request
  task automatic send_request(logic [1:0] cnt, logic [SET_W-1:0] a, logic [SET_W-1:0] b,
                              logic lamp, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.member_count <= cnt;
    in_ch.set_a        <= a;
    in_ch.set_b        <= b;
    in_ch.lamp_on      <= lamp;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(cnt, a, b, lamp);
  endtask

  // drop valid and wait until every expected result has come
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.exp_total_q.size() != 0) @(posedge clk);
  endtask

  // result side ready pattern and checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.total_cost, out_ch.infeasible);
      if (out_hold != 0) begin
        out_hold = out_hold - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (rand_stall) out_hold = gap_len();
      end
    end
  end

  // watchdog on cycles without any accepted request or taken result
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("TB_ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [SET_W-1:0] grp [8];
    int r, w;
    sb = new();
    idle_cycles = 0;
    timed_out = 0;
    rand_stall = 0;
    out_hold = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.member_count = 2'd0;
    in_ch.set_a = '0;
    in_ch.set_b = '0;
    in_ch.lamp_on = 1'b0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty items, extremes, forcing, implied, contradiction
    send_request(2'd0, 10'h3FF, 10'h3FF, 1'b1, 0);
    send_request(2'd3, 10'd5, 10'd6, 1'b0, 0);
    send_request(2'd2, 10'd0, 10'd1023, 1'b1, 0);
    send_request(2'd2, 10'd1023, 10'd0, 1'b1, 0);
    send_request(2'd2, 10'd0, 10'd1023, 1'b0, 0);
    send_request(2'd1, 10'd7, 10'd0, 1'b0, 0);
    send_request(2'd1, 10'd8, 10'd0, 1'b1, 0);
    send_request(2'd1, 10'd7, 10'd0, 1'b0, 0);
    send_request(2'd2, 10'd7, 10'd9, 1'b0, 0);
    send_request(2'd2, 10'd9, 10'd8, 1'b1, 0);
    send_request(2'd2, 10'd12, 10'd12, 1'b1, 0);
    send_request(2'd2, 10'd12, 10'd12, 1'b0, 0);
    send_request(2'd1, 10'd1023, 10'h2AA, 1'b1, 0);
    send_request(2'd1, 10'd1023, 10'h155, 1'b0, 0);
    send_request(2'd2, 10'd20, 10'd21, 1'b0, 0);
    send_request(2'd2, 10'd21, 10'd22, 1'b0, 0);
    send_request(2'd2, 10'd20, 10'd22, 1'b1, 0);

    // hold off until every result has come
    wait_drain();

    // random: small groups of sets so chains merge and contradict
    rand_stall = 1;
    for (int i = 0; i < 600; i++) begin
      if (i % 40 == 0)
        for (int k = 0; k < 8; k++) grp[k] = SET_W'($urandom_range(0, 1023));
      if (i >= 300 && i < 340) rand_stall = 0;
      else rand_stall = 1;
      r = $urandom_range(0, 99);
      w = $urandom_range(0, 1);
      if (r < 60)
        send_request(2'd2, grp[3'($urandom_range(0, 7))], grp[3'($urandom_range(0, 7))],
                     w[0], 1);
      else if (r < 85)
        send_request(2'd1, grp[3'($urandom_range(0, 7))], SET_W'($urandom()), w[0], 1);
      else if (r < 95)
        send_request(2'd2, SET_W'($urandom()), SET_W'($urandom()), w[0], 1);
      else
        send_request(2'($urandom_range(0, 3)), SET_W'($urandom()), SET_W'($urandom()),
                     w[0], 1);
    end

    // drain, then settle
    rand_stall = 0;
    wait_drain();
    repeat (50) @(posedge clk);
    $display("run covered %0d results, %0d of them flagged infeasible",
             sb.results_seen, sb.infeas_seen);
    if (sb.errors == 0 && sb.exp_total_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/puf_pkg.sv
hw/rtl/puf_in_if.sv
hw/rtl/puf_out_if.sv
hw/rtl/puf_ram.sv
hw/rtl/puf_seq.sv
hw/rtl/parity_union_find_min_cost_top.sv
test/tb_top.sv
